[sv/modbus_rtu_response_parser_unit_macros.svh]
// assertion macros for the modbus rtu response parser
`ifndef MODBUS_RTU_RESPONSE_PARSER_UNIT_MACROS_SVH
`define MODBUS_RTU_RESPONSE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

`define MRTU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MRTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRTU_ASSERT_IMPLY(label, ante, cons, msg)

`define MRTU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/mrtu_pkg.sv]
// types, constants and crc function for the modbus rtu response parser
`default_nettype none

package mrtu_pkg;

    localparam logic [7:0] EXC_MASK      = 8'h7F;
    localparam logic [7:0] FC_READ_COILS = 8'h01;
    localparam logic [7:0] FC_READ_REGS  = 8'h03;
    localparam logic [7:0] FC_WRITE_COIL = 8'h05;
    localparam logic [7:0] FC_WRITE_REG  = 8'h06;
    localparam logic [7:0] FC_WRITE_MULT = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_EXC   = 2'd2;

    localparam logic       REQ_BYTE  = 1'b0;
    localparam logic       REQ_ABORT = 1'b1;

    localparam logic       REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FIELDS,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] quantity_or_value;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        crc_ok;
    } out_word_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic is_supported(input logic [7:0] c);
        return c == FC_READ_COILS || c == FC_READ_REGS || c == FC_WRITE_COIL ||
               c == FC_WRITE_REG || c == FC_WRITE_MULT;
    endfunction

    function automatic logic is_read(input logic [7:0] c);
        return c == FC_READ_COILS || c == FC_READ_REGS;
    endfunction

endpackage

`default_nettype wire

[sv/modbus_rtu_response_parser_unit.sv]
// Modbus RTU reply parser: takes one received byte or abort per word and gives at most one
// result word per input word (payload byte, frame complete with crc outcome, or exception).
// A word is taken every clock cycle while the output side keeps taking results; each word passes
// an input register, combinational decode with a byte-wide crc-16 update, and a result register,
// which captures the result when its word leaves the input register.
// The device address register sits at APB address 0 (reset 1) and must be written only while
// the block is idle; the user is bound by this, and the block itself does not enforce it.
`default_nettype none
`include "modbus_rtu_response_parser_unit_macros.svh"

module modbus_rtu_response_parser_unit
    import mrtu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_word,

    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_word,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  device_address_reg;

    logic        item_valid_reg;
    in_word_t    item_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [15:0] prev_crc_reg, prev_crc_next;
    logic        prev_valid_reg, prev_valid_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  fc_reg, fc_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] qty_reg, qty_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic        out_valid_reg;
    out_word_t   out_word_reg;
    logic        emit;
    out_word_t   res;

    logic [7:0]  b;
    logic        abort;
    logic        hit;
    logic        fn_read;
    logic [7:0]  fc_inc;
    logic [15:0] crc_upd;

    // apb register
    assign pready = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_DEVICE_ADDRESS)
        begin
            prdata = {24'd0, device_address_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_DEVICE_ADDRESS)
        begin
            device_address_reg <= pwdata[7:0];
        end
    end

    // input register
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_word;
        end
    end

    // decode
    assign b       = item_reg.rx_byte;
    assign abort   = item_reg.req_type == REQ_ABORT;
    assign hit     = prev_valid_reg && prev_byte_reg == device_address_reg &&
                     is_supported(b & EXC_MASK);
    assign fn_read = is_read(func_reg);
    assign fc_inc  = fc_reg + 8'd1;
    assign crc_upd = crc_byte(crc_reg, b);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (abort)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (hit && !b[7])
                    begin
                        phase_next = PH_FIELDS;
                    end
                end
                PH_FIELDS:
                begin
                    if (fn_read)
                    begin
                        phase_next = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
                    end
                    else if (fc_reg >= 8'd3)
                    begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_DATA:
                begin
                    if (fc_inc >= count_reg)
                    begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        prev_byte_next  = prev_byte_reg;
        prev_crc_next   = prev_crc_reg;
        prev_valid_next = prev_valid_reg;
        func_next       = func_reg;
        fc_next         = fc_reg;
        crc_next        = crc_reg;
        addr_next       = addr_reg;
        qty_next        = qty_reg;
        count_next      = count_reg;
        crc_lo_next     = crc_lo_reg;
        emit            = 1'b0;

        res.result_kind       = KIND_DATA;
        res.function_code     = func_reg;
        res.register_address  = fn_read ? 16'd0 : addr_reg;
        res.quantity_or_value = fn_read ? 16'd0 : qty_reg;
        res.byte_count        = fn_read ? count_reg : 8'd0;
        res.data_byte         = 8'd0;
        res.data_index        = 8'd0;
        res.crc_ok            = 1'b0;

        if (abort)
        begin
            prev_valid_next = 1'b0;
            prev_byte_next  = 8'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (hit)
                    begin
                        func_next   = b;
                        crc_next    = crc_byte(prev_crc_reg, b);
                        addr_next   = 16'd0;
                        qty_next    = 16'd0;
                        count_next  = 8'd0;
                        fc_next     = 8'd0;
                        crc_lo_next = 8'd0;
                        prev_valid_next = 1'b0;
                        if (b[7])
                        begin
                            emit = 1'b1;
                            res.result_kind       = KIND_EXC;
                            res.function_code     = b;
                            res.register_address  = 16'd0;
                            res.quantity_or_value = 16'd0;
                            res.byte_count        = 8'd0;
                            prev_byte_next        = 8'd0;
                        end
                    end
                    else
                    begin
                        prev_byte_next  = b;
                        prev_crc_next   = crc_byte(CRC_INIT, b);
                        prev_valid_next = 1'b1;
                    end
                end
                PH_FIELDS:
                begin
                    crc_next = crc_upd;
                    if (fn_read)
                    begin
                        count_next = b;
                        fc_next    = 8'd0;
                    end
                    else
                    begin
                        unique case (fc_reg[1:0])
                            2'd0: addr_next = {b, addr_reg[7:0]};
                            2'd1: addr_next = {addr_reg[15:8], b};
                            2'd2: qty_next  = {b, qty_reg[7:0]};
                            default: qty_next = {qty_reg[15:8], b};
                        endcase
                        fc_next = (fc_reg >= 8'd3) ? 8'd0 : fc_inc;
                    end
                end
                PH_DATA:
                begin
                    crc_next       = crc_upd;
                    emit           = 1'b1;
                    res.data_byte  = b;
                    res.data_index = fc_reg;
                    fc_next        = (fc_inc >= count_reg) ? 8'd0 : fc_inc;
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = b;
                end
                PH_CRC_HI:
                begin
                    emit            = 1'b1;
                    res.result_kind = KIND_FRAME;
                    res.crc_ok      = {b, crc_lo_reg} == crc_reg;
                    prev_valid_next = 1'b0;
                    prev_byte_next  = 8'd0;
                end
                default:
                begin
                    prev_valid_next = 1'b0;
                    prev_byte_next  = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            prev_byte_reg  <= 8'd0;
            prev_crc_reg   <= CRC_INIT;
            prev_valid_reg <= 1'b0;
            func_reg       <= 8'd0;
            fc_reg         <= 8'd0;
            crc_reg        <= CRC_INIT;
            addr_reg       <= 16'd0;
            qty_reg        <= 16'd0;
            count_reg      <= 8'd0;
            crc_lo_reg     <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            prev_byte_reg  <= prev_byte_next;
            prev_crc_reg   <= prev_crc_next;
            prev_valid_reg <= prev_valid_next;
            func_reg       <= func_next;
            fc_reg         <= fc_next;
            crc_reg        <= crc_next;
            addr_reg       <= addr_next;
            qty_reg        <= qty_next;
            count_reg      <= count_next;
            crc_lo_reg     <= crc_lo_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `MRTU_ASSERT_IMPLY(a_data_phase_read, phase_reg == PH_DATA,
        count_reg != 8'd0 && fn_read, "data phase without a read frame")
    `MRTU_ASSERT_IMPLY(a_fields_count, phase_reg == PH_FIELDS, fc_reg <= 8'd3,
        "field counter beyond header")
    `MRTU_ASSERT_IMPLY(a_index_in_range,
        out_valid_reg && out_word_reg.result_kind == KIND_DATA,
        out_word_reg.data_index < out_word_reg.byte_count, "payload index past byte count")
    `MRTU_ASSERT_IMPLY(a_exc_code, out_valid_reg && out_word_reg.result_kind == KIND_EXC,
        out_word_reg.function_code[7], "exception without exception bit")
    `MRTU_ASSERT_NEXT(a_abort_hunt, advance && abort,
        phase_reg == PH_HUNT && !prev_valid_reg, "abort did not return to hunting")

endmodule

`default_nettype wire
